@@ design/png_stream_extractor_macros.svh @@
// ----------------------------------------------------------------------------
// PNG stream extractor assertion macros
// Shared helpers for the concurrent checks of the extractor.
// ----------------------------------------------------------------------------
`ifndef PNG_STREAM_EXTRACTOR_MACROS_SVH
`define PNG_STREAM_EXTRACTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("png_stream_extractor check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("png_stream_extractor check failed");

`endif

@@ design/pse_pkg.sv @@
// ----------------------------------------------------------------------------
// PNG stream extractor package
// Item types, status codes and constants shared by the extractor files.
// ----------------------------------------------------------------------------
package pse_pkg;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_DONE = 2'd1,
    ST_FAIL = 2'd2,
    ST_NONE = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    status_e    status;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [31:0] max_chunk_length;
  } cfg_item_t;

  // One queued entry: either a single result or the whole signature burst.
  typedef struct packed {
    logic       burst;
    logic [7:0] out_byte;
    logic       byte_valid;
    status_e    status;
  } desc_t;

  localparam logic [31:0] MaxChunkLengthReset = 32'd5242880;
  localparam logic [31:0] TypeIend            = 32'h49454E44;
  localparam logic [7:0]  SigLead             = 8'h89;
  localparam int unsigned SigLen              = 8;
  localparam int unsigned SigIdxW             = $clog2(SigLen);

  function automatic logic [7:0] sig_byte(input logic [SigIdxW-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = SigLead;
      3'd1:    b = 8'h50;
      3'd2:    b = 8'h4E;
      3'd3:    b = 8'h47;
      3'd4:    b = 8'h0D;
      3'd5:    b = 8'h0A;
      3'd6:    b = 8'h1A;
      default: b = 8'h0A;
    endcase
    return b;
  endfunction

endpackage

@@ design/pse_stream_if.sv @@
// ----------------------------------------------------------------------------
// PNG stream extractor channel
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface pse_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ design/png_stream_extractor.sv @@
// ----------------------------------------------------------------------------
// PNG stream extractor
// Finds the first PNG in a byte stream and passes its chunks through.
// ----------------------------------------------------------------------------
// Usage: in_i takes one file byte per item, with end_of_stream set on the
// final byte of the file. out_o delivers the extracted PNG as items: the
// eight signature bytes once the signature has been seen, then every chunk
// byte, with a status of running, done (last CRC byte of IEND), failed
// (oversized chunk length or end of stream inside the PNG) or not found.
// last_of_run marks the final item caused by one input byte. When an item
// reports failed, the receiver drops every byte already sent for this PNG.
// cfg_i writes max_chunk_length; its ready is always high and it should only
// be written while the block is idle.
// The first result of an item is registered in the output queue.
// Throughput: one input byte per cycle while the output queue has room;
// the signature item produces eight output items, so input stalls after it
// while the two-entry output queue drains at one item per cycle when out_o is ready.
// A stall on out_o holds the current item; the queue absorbs one more entry
// and then in_i.ready drops until the receiver takes items again.
// Reset clears the parser to scanning and loads max_chunk_length with 5 MiB.
// End of stream also returns the parser to scanning, keeping the register.
// ----------------------------------------------------------------------------
module png_stream_extractor (
  input  logic         clk_i,
  input  logic         rst_ni,
  pse_stream_if.sink   in_i,
  pse_stream_if.sink   cfg_i,
  pse_stream_if.source out_o
);
  import pse_pkg::*;

  typedef enum logic [3:0] {
    PH_SCAN = 4'b0001,
    PH_HEAD = 4'b0010,
    PH_BODY = 4'b0100,
    PH_FIN  = 4'b1000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  sig_matched_q, sig_matched_d;
  logic [2:0]  hdr_pos_q, hdr_pos_d;
  logic [31:0] chunk_len_q, chunk_len_d;
  logic [31:0] chunk_type_q, chunk_type_d;
  logic [32:0] bytes_rem_q, bytes_rem_d;
  logic [31:0] max_len_q;

  logic        accept;
  logic        queue_full;
  logic        produce;
  logic        ended;
  desc_t       desc;
  logic [3:0]  sm_cur;
  logic [3:0]  sm_next;
  logic [32:0] br_dec;
  logic [7:0]  in_byte;

  assign in_byte     = in_i.payload.data_byte;
  assign in_i.ready  = !queue_full;
  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Match counter restarts at one on a stray lead byte, else at zero.
  assign sm_cur  = (sig_matched_q > 4'd7) ? 4'd0 : sig_matched_q;
  assign sm_next = (in_byte == sig_byte(sm_cur[2:0])) ? (sm_cur + 4'd1)
                 : ((in_byte == SigLead) ? 4'd1 : 4'd0);
  assign br_dec  = (bytes_rem_q != '0) ? (bytes_rem_q - 33'd1) : '0;

  always_comb begin
    phase_d       = phase_q;
    sig_matched_d = sig_matched_q;
    hdr_pos_d     = hdr_pos_q;
    chunk_len_d   = chunk_len_q;
    chunk_type_d  = chunk_type_q;
    bytes_rem_d   = bytes_rem_q;
    produce       = 1'b0;
    ended         = 1'b0;
    desc          = '0;
    desc.status   = ST_RUN;

    unique case (phase_q)
      PH_SCAN: begin
        sig_matched_d = sm_next;
        if (sm_next == 4'd8) begin
          produce         = 1'b1;
          desc.burst      = 1'b1;
          desc.byte_valid = 1'b1;
          sig_matched_d   = '0;
          hdr_pos_d       = '0;
          phase_d         = PH_HEAD;
        end
      end
      PH_HEAD: begin
        produce = 1'b1;
        if (!hdr_pos_q[2]) begin
          chunk_len_d = {chunk_len_q[23:0], in_byte};
        end else begin
          chunk_type_d = {chunk_type_q[23:0], in_byte};
        end
        hdr_pos_d = hdr_pos_q + 3'd1;
        if (hdr_pos_q == 3'd7) begin
          // The length is complete after the fourth header byte.
          if (chunk_len_q > max_len_q) begin
            desc.status = ST_FAIL;
            phase_d     = PH_FIN;
            ended       = 1'b1;
          end else begin
            desc.out_byte   = in_byte;
            desc.byte_valid = 1'b1;
            bytes_rem_d     = {1'b0, chunk_len_q} + 33'd4;
            phase_d         = PH_BODY;
          end
        end else begin
          desc.out_byte   = in_byte;
          desc.byte_valid = 1'b1;
        end
      end
      PH_BODY: begin
        produce         = 1'b1;
        desc.out_byte   = in_byte;
        desc.byte_valid = 1'b1;
        bytes_rem_d     = br_dec;
        if (br_dec == '0) begin
          if (chunk_type_q == TypeIend) begin
            desc.status = ST_DONE;
            phase_d     = PH_FIN;
            ended       = 1'b1;
          end else begin
            chunk_len_d  = '0;
            chunk_type_d = '0;
            hdr_pos_d    = '0;
            phase_d      = PH_HEAD;
          end
        end
      end
      default: begin
        // Finished: bytes are dropped until end of stream.
        ended = 1'b1;
      end
    endcase

    if (in_i.payload.end_of_stream) begin
      if (!ended) begin
        if (produce) begin
          desc.status = ST_FAIL;
        end else begin
          produce     = 1'b1;
          desc        = '0;
          desc.status = ST_NONE;
        end
      end
      phase_d       = PH_SCAN;
      sig_matched_d = '0;
      hdr_pos_d     = '0;
      chunk_len_d   = '0;
      chunk_type_d  = '0;
      bytes_rem_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_SCAN;
      sig_matched_q <= '0;
      hdr_pos_q     <= '0;
      chunk_len_q   <= '0;
      chunk_type_q  <= '0;
      bytes_rem_q   <= '0;
      max_len_q     <= MaxChunkLengthReset;
    end else begin
      if (accept) begin
        phase_q       <= phase_d;
        sig_matched_q <= sig_matched_d;
        hdr_pos_q     <= hdr_pos_d;
        chunk_len_q   <= chunk_len_d;
        chunk_type_q  <= chunk_type_d;
        bytes_rem_q   <= bytes_rem_d;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        max_len_q <= cfg_i.payload.max_chunk_length;
      end
    end
  end

  pse_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && produce),
    .push_desc_i (desc),
    .full_o      (queue_full),
    .out_o       (out_o)
  );

endmodule

@@ design/pse_out_queue.sv @@
// ----------------------------------------------------------------------------
// PNG stream extractor output queue
// Two-entry queue of result entries; a signature entry expands into eight items.
// ----------------------------------------------------------------------------
module pse_out_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pse_pkg::desc_t push_desc_i,
  output logic          full_o,
  pse_stream_if.source  out_o
);
  import pse_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  desc_t               entries_q [Depth];
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [SigIdxW-1:0]  idx_q, idx_d;
  desc_t               head;
  logic                fire;
  logic                last_beat;
  logic                pop;

  assign head      = entries_q[rd_ptr_q];
  assign full_o    = (count_q == CntW'(Depth));
  assign fire      = out_o.valid && out_o.ready;
  assign last_beat = !head.burst || (idx_q == SigIdxW'(SigLen - 1));
  assign pop       = fire && last_beat;

  assign out_o.valid = (count_q != '0);

  always_comb begin
    out_o.payload.out_byte    = head.burst ? sig_byte(idx_q) : head.out_byte;
    out_o.payload.byte_valid  = head.burst ? 1'b1 : head.byte_valid;
    out_o.payload.status      = last_beat ? head.status : ST_RUN;
    out_o.payload.last_of_run = last_beat;
  end

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    idx_d    = idx_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (fire) begin
      if (last_beat) begin
        rd_ptr_d = rd_ptr_q + 1'b1;
        idx_d    = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
    priority if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push_i) begin
      count_d = count_q - 1'b1;
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
      idx_q    <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

@@ design/pse_checker.sv @@
// ----------------------------------------------------------------------------
// PNG stream extractor checker
// Port-level checks on the result channel of the extractor.
// ----------------------------------------------------------------------------
`include "png_stream_extractor_macros.svh"

module pse_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input pse_pkg::out_item_t  out_payload_i
);
  import pse_pkg::*;

  // A stalled item stays offered and unchanged.
  `PSE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_payload_i))

  // Items without a file byte carry a zero byte.
  `PSE_ASSERT_IMPL(a_nobyte_zero, clk_i, rst_ni, out_valid_i && !out_payload_i.byte_valid, out_payload_i.out_byte == 8'd0)

  // Only the final item of an input byte reports a terminal status.
  `PSE_ASSERT_IMPL(a_status_last, clk_i, rst_ni, out_valid_i && (out_payload_i.status != ST_RUN), out_payload_i.last_of_run)

  // Items without a file byte are always failed or not found.
  `PSE_ASSERT_IMPL(a_nobyte_status, clk_i, rst_ni, out_valid_i && !out_payload_i.byte_valid, (out_payload_i.status == ST_FAIL) || (out_payload_i.status == ST_NONE))

endmodule

bind png_stream_extractor pse_checker u_pse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);
